>>> design/ipv6_alt_pkg.sv
// ----------------------------------------------------------------------------
// ipv6_alt_pkg
// shared types and constants of the ipv6 address lifetime table
// ----------------------------------------------------------------------------
`default_nettype none
package ipv6_alt_pkg;
   localparam logic [31:0] LIFE_INF    = 32'hFFFF_FFFF;
   localparam logic [9:0]  TPS_RESET   = 10'd100;
   localparam logic [63:0] GRP_HI      = 64'hFF02_0000_0000_0000;
   localparam logic [63:0] ALLNODES_LO = 64'h0000_0000_0000_0001;
   localparam logic [39:0] SOLNODE_TOP = 40'h00_0000_01FF;

   localparam logic [2:0] ACT_ADD     = 3'd0;
   localparam logic [2:0] ACT_DELETE  = 3'd1;
   localparam logic [2:0] ACT_LOOKUP  = 3'd2;
   localparam logic [2:0] ACT_TICK    = 3'd3;
   localparam logic [2:0] ACT_CONFIRM = 3'd4;

   localparam logic [1:0] ST_TENT = 2'd0;
   localparam logic [1:0] ST_PREF = 2'd1;
   localparam logic [1:0] ST_DEPR = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  prefix_len;
      logic        autoconf;
      logic [31:0] pref_life;
      logic [31:0] valid_life;
      logic        pref_inf;
      logic        valid_inf;
      logic        grp_hi;
      logic        allnodes;
   } cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] slot;
      logic       found;
      logic       usable;
      logic       group_member;
      logic [1:0] entry_state;
      logic [3:0] expired_count;
   } rsp_type;
endpackage
`default_nettype wire

>>> design/ipv6_alt_front.sv
// ----------------------------------------------------------------------------
// ipv6_alt_front
// request intake: classifies the request and queues it for the table engine
// ----------------------------------------------------------------------------
`default_nettype none
module ipv6_alt_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire  [2:0]             req_action,
   input  wire  [63:0]            req_addr_hi,
   input  wire  [63:0]            req_addr_lo,
   input  wire  [7:0]             req_prefix_len,
   input  wire                    req_autoconf,
   input  wire  [31:0]            req_pref_life,
   input  wire  [31:0]            req_valid_life,
   output logic                   cmd_valid,
   input  wire                    cmd_take,
   output ipv6_alt_pkg::cmd_type  cmd
);
   import ipv6_alt_pkg::*;

   // two entry queue
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   cmd_type    c_in;
   logic       do_push;

   always_comb begin
      c_in.action     = req_action;
      c_in.addr_hi    = req_addr_hi;
      c_in.addr_lo    = req_addr_lo;
      c_in.prefix_len = req_prefix_len;
      c_in.autoconf   = req_autoconf;
      c_in.pref_life  = req_pref_life;
      c_in.valid_life = req_valid_life;
      c_in.pref_inf   = (req_pref_life == LIFE_INF);
      c_in.valid_inf  = (req_valid_life == LIFE_INF);
      c_in.grp_hi     = (req_addr_hi == GRP_HI);
      c_in.allnodes   = (req_addr_lo == ALLNODES_LO);
   end

   assign full      = (cnt_ff == 2'd2);
   assign do_push   = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wp_ff] <= c_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         if (do_push) wp_ff <= !wp_ff;
         if (cmd_take) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, cmd_take};
      end
   end
endmodule
`default_nettype wire

>>> design/ipv6_alt_engine.sv
// ----------------------------------------------------------------------------
// ipv6_alt_engine
// table engine: walks the entries one per cycle and applies the request
// ----------------------------------------------------------------------------
`default_nettype none
module ipv6_alt_engine #(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [9:0]             tps,
   input  wire                    cmd_valid,
   output logic                   cmd_take,
   input  ipv6_alt_pkg::cmd_type  cmd,
   output logic                   rsp_valid,
   input  wire                    rsp_take,
   output ipv6_alt_pkg::rsp_type  rsp
);
   import ipv6_alt_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SCAN, S_APPLY, S_OUT
   } state_type;

   state_type   state_ff;
   cmd_type     c_ff;
   logic [IW-1:0] idx_ff;
   logic        hit_ff, free_ok_ff, grp_ff;
   logic [IW-1:0] hit_idx_ff, free_ff;
   logic [3:0]  cnt_ff;
   logic [63:0] now_ff;
   logic [41:0] pmul_ff, vmul_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic                valid_ff  [TABLE_ENTRIES];
   logic [63:0]         ahi_ff    [TABLE_ENTRIES];
   logic [63:0]         alo_ff    [TABLE_ENTRIES];
   logic [7:0]          pfx_ff    [TABLE_ENTRIES];
   logic                auto_ff   [TABLE_ENTRIES];
   logic [1:0]          st_ff     [TABLE_ENTRIES];
   logic [63:0]         pdl_ff    [TABLE_ENTRIES];
   logic [63:0]         vdl_ff    [TABLE_ENTRIES];
   logic                pinf_ff   [TABLE_ENTRIES];
   logic                vinf_ff   [TABLE_ENTRIES];

   logic          e_match, e_grp, last;
   logic [IW-1:0] tgt;
   logic [63:0]   pdl_new, vdl_new;

   assign e_match = valid_ff[idx_ff] && ahi_ff[idx_ff] == c_ff.addr_hi
                    && alo_ff[idx_ff] == c_ff.addr_lo;
   assign e_grp   = valid_ff[idx_ff]
                    && c_ff.addr_lo == {SOLNODE_TOP, alo_ff[idx_ff][23:0]};
   assign last    = (idx_ff == IW'(TABLE_ENTRIES - 1));
   assign tgt     = hit_ff ? hit_idx_ff : free_ff;
   assign pdl_new = c_ff.pref_inf ? 64'd0 : now_ff + {22'd0, pmul_ff};
   assign vdl_new = c_ff.valid_inf ? 64'd0 : now_ff + {22'd0, vmul_ff};

   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp       = rsp_ff;

   // result of the request, from the table as it stands before the apply step
   always_comb begin
      rsp_in = '0;
      case (c_ff.action)
         ACT_ADD: begin
            if (hit_ff || free_ok_ff) begin
               rsp_in.slot  = 3'(tgt);
               rsp_in.found = 1'b1;
               if (hit_ff) begin
                  if (st_ff[tgt] == ST_DEPR && c_ff.pref_life != 32'd0) begin
                     rsp_in.entry_state = ST_PREF;
                     rsp_in.usable      = 1'b1;
                  end else begin
                     rsp_in.entry_state = st_ff[tgt];
                     rsp_in.usable      = (st_ff[tgt] != ST_TENT);
                  end
               end
            end else begin
               rsp_in.status = STS_FULL;
            end
         end
         ACT_DELETE: begin
            if (hit_ff) begin
               rsp_in.slot  = 3'(hit_idx_ff);
               rsp_in.found = 1'b1;
            end else rsp_in.status = STS_NOTFOUND;
         end
         ACT_LOOKUP, ACT_CONFIRM: begin
            if (c_ff.action == ACT_LOOKUP) rsp_in.group_member = grp_ff;
            if (hit_ff) begin
               rsp_in.slot  = 3'(hit_idx_ff);
               rsp_in.found = 1'b1;
               if (c_ff.action == ACT_CONFIRM && st_ff[hit_idx_ff] == ST_TENT) begin
                  rsp_in.entry_state = ST_PREF;
                  rsp_in.usable      = 1'b1;
               end else begin
                  rsp_in.entry_state = st_ff[hit_idx_ff];
                  rsp_in.usable      = (st_ff[hit_idx_ff] != ST_TENT);
               end
            end else rsp_in.status = STS_NOTFOUND;
         end
         ACT_TICK: rsp_in.expired_count = cnt_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         now_ff   <= 64'd0;
         for (int i = 0; i < TABLE_ENTRIES; i++) valid_ff[i] <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  c_ff       <= cmd;
                  idx_ff     <= '0;
                  hit_ff     <= 1'b0;
                  free_ok_ff <= 1'b0;
                  grp_ff     <= cmd.grp_hi && cmd.allnodes;
                  cnt_ff     <= 4'd0;
                  hit_idx_ff <= '0;
                  free_ff    <= '0;
                  if (cmd.action == ACT_TICK) now_ff <= now_ff + 64'd1;
                  state_ff   <= S_MUL;
               end
            end
            S_MUL: begin
               pmul_ff  <= {10'd0, c_ff.pref_life} * {32'd0, tps};
               vmul_ff  <= {10'd0, c_ff.valid_life} * {32'd0, tps};
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (c_ff.action == ACT_TICK) begin
                  if (valid_ff[idx_ff]) begin
                     if (!vinf_ff[idx_ff] && now_ff >= vdl_ff[idx_ff]) begin
                        valid_ff[idx_ff] <= 1'b0;
                        if (cnt_ff != 4'd15) cnt_ff <= cnt_ff + 4'd1;
                     end else if (st_ff[idx_ff] == ST_PREF && !pinf_ff[idx_ff]
                                  && now_ff >= pdl_ff[idx_ff]) begin
                        st_ff[idx_ff] <= ST_DEPR;
                     end
                  end
               end else begin
                  if (e_match && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= idx_ff;
                  end
                  if (!valid_ff[idx_ff] && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff    <= idx_ff;
                  end
                  if (c_ff.grp_hi && e_grp) grp_ff <= 1'b1;
               end
               if (last) state_ff <= S_APPLY;
               else idx_ff <= idx_ff + IW'(1);
            end
            S_APPLY: begin
               rsp_ff <= rsp_in;
               case (c_ff.action)
                  ACT_ADD: begin
                     if (hit_ff || free_ok_ff) begin
                        pdl_ff[tgt]  <= pdl_new;
                        vdl_ff[tgt]  <= vdl_new;
                        pinf_ff[tgt] <= c_ff.pref_inf;
                        vinf_ff[tgt] <= c_ff.valid_inf;
                        if (hit_ff) begin
                           if (st_ff[tgt] == ST_DEPR && c_ff.pref_life != 32'd0)
                              st_ff[tgt] <= ST_PREF;
                        end else begin
                           valid_ff[tgt] <= 1'b1;
                           ahi_ff[tgt]   <= c_ff.addr_hi;
                           alo_ff[tgt]   <= c_ff.addr_lo;
                           pfx_ff[tgt]   <= c_ff.prefix_len;
                           auto_ff[tgt]  <= c_ff.autoconf;
                           st_ff[tgt]    <= ST_TENT;
                        end
                     end
                  end
                  ACT_DELETE: begin
                     if (hit_ff) valid_ff[hit_idx_ff] <= 1'b0;
                  end
                  ACT_CONFIRM: begin
                     if (hit_ff && st_ff[hit_idx_ff] == ST_TENT)
                        st_ff[hit_idx_ff] <= ST_PREF;
                  end
                  default: ;
               endcase
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_take) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // prefix and autoconf are held for later readers; keep them observed
   logic unused_keep;
   assign unused_keep = ^{pfx_ff[0], auto_ff[0]};
endmodule
`default_nettype wire

>>> design/ipv6_alt_back.sv
// ----------------------------------------------------------------------------
// ipv6_alt_back
// result queue: holds finished results until popped
// ----------------------------------------------------------------------------
`default_nettype none
module ipv6_alt_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_take,
   input  ipv6_alt_pkg::rsp_type  in_rsp,
   output logic                   empty,
   input  wire                    pop,
   output ipv6_alt_pkg::rsp_type  out_rsp
);
   import ipv6_alt_pkg::*;

   rsp_type r_ff;
   logic    v_ff;

   assign empty   = !v_ff;
   assign in_take = in_valid && (!v_ff || pop);
   assign out_rsp = r_ff;

   always_ff @(posedge clock) begin
      if (in_take) r_ff <= in_rsp;
      if (reset) v_ff <= 1'b0;
      else if (in_take) v_ff <= 1'b1;
      else if (pop) v_ff <= 1'b0;
   end
endmodule
`default_nettype wire

>>> design/ipv6_address_lifetime_table_unit.sv
// ----------------------------------------------------------------------------
// ipv6_address_lifetime_table_unit
// ipv6 interface address table with preferred and valid lifetimes
// ----------------------------------------------------------------------------
// Requests enter a two deep queue and are taken by a table engine that walks
// the TABLE_ENTRIES slots one per cycle. Each request passes through the engine
// in steps: it is taken, the lifetimes are multiplied, each slot is visited,
// the change is applied, and the result is handed over; the engine takes no
// new request until then, and the slot walk sets the rate. Results wait in a one
// deep result register while the engine already works on the next request.
`default_nettype none
module ipv6_address_lifetime_table_unit #(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [2:0]  req_action,
   input  wire  [63:0] req_addr_hi,
   input  wire  [63:0] req_addr_lo,
   input  wire  [7:0]  req_prefix_len,
   input  wire         req_autoconf,
   input  wire  [31:0] req_pref_life,
   input  wire  [31:0] req_valid_life,
   output logic        empty,
   input  wire         pop,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_slot,
   output logic        rsp_found,
   output logic        rsp_usable,
   output logic        rsp_group_member,
   output logic [1:0]  rsp_entry_state,
   output logic [3:0]  rsp_expired_count,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [9:0]  csr_data
);
   import ipv6_alt_pkg::*;

   logic     cmd_valid, cmd_take, eng_valid, eng_take;
   cmd_type  cmd;
   rsp_type  eng_rsp, out_rsp;
   logic [9:0] tps_ff;

   // ticks per second register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) tps_ff <= TPS_RESET;
      else if (csr_valid) tps_ff <= csr_data;
   end

   ipv6_alt_front u_front (
      .clock, .reset, .push, .full,
      .req_action, .req_addr_hi, .req_addr_lo, .req_prefix_len,
      .req_autoconf, .req_pref_life, .req_valid_life,
      .cmd_valid, .cmd_take, .cmd
   );

   ipv6_alt_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
      .clock, .reset, .tps(tps_ff),
      .cmd_valid, .cmd_take, .cmd,
      .rsp_valid(eng_valid), .rsp_take(eng_take), .rsp(eng_rsp)
   );

   ipv6_alt_back u_back (
      .clock, .reset,
      .in_valid(eng_valid), .in_take(eng_take), .in_rsp(eng_rsp),
      .empty, .pop, .out_rsp
   );

   assign rsp_status        = out_rsp.status;
   assign rsp_slot          = out_rsp.slot;
   assign rsp_found         = out_rsp.found;
   assign rsp_usable        = out_rsp.usable;
   assign rsp_group_member  = out_rsp.group_member;
   assign rsp_entry_state   = out_rsp.entry_state;
   assign rsp_expired_count = out_rsp.expired_count;
endmodule
`default_nettype wire

>>> design/ipv6_alt_checker.sv
// ----------------------------------------------------------------------------
// ipv6_alt_checker
// port level checks of the address table
// ----------------------------------------------------------------------------
`default_nettype none
module ipv6_alt_checker (
   input wire       clock,
   input wire       reset,
   input wire       empty,
   input wire       pop,
   input wire [1:0] rsp_status,
   input wire       rsp_found,
   input wire       rsp_usable,
   input wire [3:0] rsp_expired_count,
   input wire       csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty) else $error("result dropped");
   a_usable: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_usable |-> rsp_found) else $error("usable without found");
   a_found: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_found |-> rsp_status == 2'd0) else $error("found with error");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_expired_count != 4'd0 |-> !rsp_found) else $error("bad count");
   a_csr: assert property (@(posedge clock) csr_ready) else $error("csr stalled");
endmodule

bind ipv6_address_lifetime_table_unit ipv6_alt_checker u_checker (
   .clock, .reset, .empty, .pop, .rsp_status, .rsp_found, .rsp_usable,
   .rsp_expired_count, .csr_ready
);
`default_nettype wire
